[hdl/kfl_pkg.sv]
// Shared types, codes and defaults for the keyed FIFO list.
`default_nettype none

package kfl_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 16;

    // Fixed widths of the stream fields.
    localparam int KEY_W    = 16;
    localparam int HANDLE_W = 16;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int ECOUNT_W = 5;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    // What a cell loads on the next clock edge.
    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_SHIFT,
        SEL_WRAP,
        SEL_LOAD
    } cell_sel_t;

    // Chain-wide moves issued by the controller.
    typedef struct packed {
        logic append;
        logic drop;
        logic rotate;
    } chain_ctl_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } kfl_state_t;

endpackage : kfl_pkg

`default_nettype wire

[hdl/keyed_fifo_list_top.sv]
// Top level of the keyed FIFO list: the cell chain and its controller.
`default_nettype none

// The keyed FIFO list keeps up to DEPTH entries, each an id and a handle, in
// arrival order in a chain of cells where cell 0 holds the oldest entry while
// the controller is idle. Commands arrive on the slave stream (command in
// s_tuser, id and handle in s_tdata) and each produces exactly one result
// transfer on the master stream (status in m_tuser, handle, id and entry count
// in m_tdata). Insert writes the cell just past the tail and pop shifts every
// cell one place toward the head. For delete and lookup on a non-empty store
// the chain rotates as a ring of the current length, every entry passing the
// id comparator at cell 0 once, so a single compare on the head cell serves
// the whole store. A delete drops the first matching entry as it reaches the
// head instead of rotating it, and after the pass the order is the original
// one. A new command is accepted whenever the controller is idle and the
// result register is empty or being read in the same cycle, so a result that
// has not been read holds off the next command. Ids are kept to ID_BITS bits;
// entry_count reports the fill count modulo 32.
module keyed_fifo_list_top #(
    parameter int DEPTH   = kfl_pkg::DEPTH_DEF,
    parameter int ID_BITS = kfl_pkg::ID_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Command stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // [15:0] key_id, [31:16] item_handle
    input  wire logic [7:0]  s_tuser,  // [1:0] command, [7:2] zero
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,  // [15:0] found_handle, [31:16] found_id,
                                       // [36:32] entry_count, [39:37] zero
    output logic      [7:0]  m_tuser   // [1:0] status, [7:2] zero
);
    import kfl_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field views of the command transfer.
    logic [CMD_W-1:0]    cmd_in;
    logic [KEY_W-1:0]    key_in;
    logic [HANDLE_W-1:0] handle_in;
    logic [ID_BITS-1:0]  key_masked;

    assign cmd_in     = s_tuser[CMD_W-1:0];
    assign key_in     = s_tdata[KEY_W-1:0];
    assign handle_in  = s_tdata[KEY_W +: HANDLE_W];
    // The stored id is the key taken to ID_BITS bits.
    assign key_masked = ID_BITS'(key_in);

    // Chain storage as seen from outside the cells.
    logic [ID_BITS-1:0]  cell_id     [DEPTH];
    logic [HANDLE_W-1:0] cell_handle [DEPTH];

    chain_ctl_t       chain;
    logic [CNT_W-1:0] count;

    logic [STATUS_W-1:0] res_status;
    logic [HANDLE_W-1:0] res_handle;
    logic [KEY_W-1:0]    res_id;
    logic [ECOUNT_W-1:0] res_count;

    kfl_ctrl #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_cmd       (cmd_in),
        .s_key       (key_masked),
        .head_id     (cell_id[0]),
        .head_handle (cell_handle[0]),
        .chain       (chain),
        .count       (count),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_status    (res_status),
        .m_handle    (res_handle),
        .m_id        (res_id),
        .m_count     (res_count)
    );

    // Each cell works out its own move from the chain command and its place
    // relative to the fill count. On a rotate the tail cell takes the head
    // entry and every other cell takes its younger neighbor; on a drop every
    // cell takes its neighbor; on an append only the cell past the tail loads.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        cell_sel_t           sel;
        logic [ID_BITS-1:0]  nbr_id;
        logic [HANDLE_W-1:0] nbr_handle;

        if (i < DEPTH - 1) begin : g_nbr
            assign nbr_id     = cell_id[i + 1];
            assign nbr_handle = cell_handle[i + 1];
        end else begin : g_last
            assign nbr_id     = '0;
            assign nbr_handle = '0;
        end

        always_comb begin
            sel = SEL_HOLD;
            if (chain.append && count == CNT_W'(i)) begin
                sel = SEL_LOAD;
            end else if (chain.drop) begin
                sel = SEL_SHIFT;
            end else if (chain.rotate) begin
                sel = (count == CNT_W'(i + 1)) ? SEL_WRAP : SEL_SHIFT;
            end
        end

        kfl_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .aclk        (aclk),
            .sel         (sel),
            .nbr_id      (nbr_id),
            .nbr_handle  (nbr_handle),
            .head_id     (cell_id[0]),
            .head_handle (cell_handle[0]),
            .load_id     (key_masked),
            .load_handle (handle_in),
            .id          (cell_id[i]),
            .handle      (cell_handle[i])
        );
    end

    // Result packing, lowest field first.
    assign m_tdata = {3'b000, res_count, res_id, res_handle};
    assign m_tuser = {6'b000000, res_status};

endmodule : keyed_fifo_list_top

`default_nettype wire

[hdl/kfl_cell.sv]
// One storage cell of the chain: an id and a handle with a four-way input select.
`default_nettype none

module kfl_cell #(
    parameter int ID_BITS = kfl_pkg::ID_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire kfl_pkg::cell_sel_t          sel,
    input  wire logic [ID_BITS-1:0]          nbr_id,
    input  wire logic [kfl_pkg::HANDLE_W-1:0] nbr_handle,
    input  wire logic [ID_BITS-1:0]          head_id,
    input  wire logic [kfl_pkg::HANDLE_W-1:0] head_handle,
    input  wire logic [ID_BITS-1:0]          load_id,
    input  wire logic [kfl_pkg::HANDLE_W-1:0] load_handle,
    output logic      [ID_BITS-1:0]          id,
    output logic      [kfl_pkg::HANDLE_W-1:0] handle
);
    import kfl_pkg::*;

    logic [ID_BITS-1:0]  id_reg, id_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;

    always_comb begin
        id_next     = id_reg;
        handle_next = handle_reg;
        case (sel)
            SEL_SHIFT: begin
                id_next     = nbr_id;
                handle_next = nbr_handle;
            end
            SEL_WRAP: begin
                id_next     = head_id;
                handle_next = head_handle;
            end
            SEL_LOAD: begin
                id_next     = load_id;
                handle_next = load_handle;
            end
            default: begin
                id_next     = id_reg;
                handle_next = handle_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        id_reg     <= id_next;
        handle_reg <= handle_next;
    end

    assign id     = id_reg;
    assign handle = handle_reg;

endmodule : kfl_cell

`default_nettype wire

[hdl/kfl_ctrl.sv]
// Command sequencer, fill count and result register of the keyed FIFO list.
`default_nettype none

module kfl_ctrl #(
    parameter int DEPTH   = kfl_pkg::DEPTH_DEF,
    parameter int ID_BITS = kfl_pkg::ID_BITS_DEF,
    localparam int CNT_W  = $clog2(DEPTH + 1)
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // Command side.
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [kfl_pkg::CMD_W-1:0]    s_cmd,
    input  wire logic [ID_BITS-1:0]           s_key,
    // Head cell contents.
    input  wire logic [ID_BITS-1:0]           head_id,
    input  wire logic [kfl_pkg::HANDLE_W-1:0] head_handle,
    // Chain control.
    output kfl_pkg::chain_ctl_t               chain,
    output logic      [CNT_W-1:0]             count,
    // Result side.
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [kfl_pkg::STATUS_W-1:0] m_status,
    output logic      [kfl_pkg::HANDLE_W-1:0] m_handle,
    output logic      [kfl_pkg::KEY_W-1:0]    m_id,
    output logic      [kfl_pkg::ECOUNT_W-1:0] m_count
);
    import kfl_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    kfl_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    steps_reg, steps_next;
    logic [ID_BITS-1:0]  key_reg, key_next;
    logic                scan_del_reg, scan_del_next;
    logic                hit_reg, hit_next;
    logic [HANDLE_W-1:0] hit_handle_reg, hit_handle_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [HANDLE_W-1:0] rhandle_reg, rhandle_next;
    logic [KEY_W-1:0]    rid_reg, rid_next;
    logic [ECOUNT_W-1:0] rcount_reg, rcount_next;

    logic s_fire;
    logic match;

    assign s_ready = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;
    assign match   = !hit_reg && (head_id == key_reg);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        steps_next      = steps_reg;
        key_next        = key_reg;
        scan_del_next   = scan_del_reg;
        hit_next        = hit_reg;
        hit_handle_next = hit_handle_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        status_next     = status_reg;
        rhandle_next    = rhandle_reg;
        rid_next        = rid_reg;
        rcount_next     = rcount_reg;
        chain           = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    out_valid_next = 1'b1;
                    status_next    = STAT_OK;
                    rhandle_next   = '0;
                    rid_next       = '0;
                    rcount_next    = ECOUNT_W'(count_reg);
                    case (s_cmd)
                        CMD_INSERT: begin
                            if (count_reg == FULL_CNT) begin
                                status_next = STAT_FULL;
                            end else begin
                                chain.append = 1'b1;
                                count_next   = count_reg + CNT_W'(1);
                                rid_next     = KEY_W'(s_key);
                                rcount_next  = ECOUNT_W'(count_reg + CNT_W'(1));
                            end
                        end
                        CMD_POP: begin
                            if (count_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                chain.drop   = 1'b1;
                                count_next   = count_reg - CNT_W'(1);
                                rid_next     = KEY_W'(head_id);
                                rhandle_next = head_handle;
                                rcount_next  = ECOUNT_W'(count_reg - CNT_W'(1));
                            end
                        end
                        CMD_DELETE, CMD_LOOKUP: begin
                            if (count_reg == '0) begin
                                status_next = STAT_NOT_FOUND;
                            end else begin
                                // Result comes at the end of the scan.
                                out_valid_next = 1'b0;
                                state_next     = ST_SCAN;
                                steps_next     = count_reg;
                                key_next       = s_key;
                                scan_del_next  = (s_cmd == CMD_DELETE);
                                hit_next       = 1'b0;
                            end
                        end
                        default: begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // The head entry is either dropped (first match of a delete)
                // or rotated to the tail; once every entry has passed the
                // head the order is restored.
                if (match && scan_del_reg) begin
                    chain.drop = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    chain.rotate = 1'b1;
                end
                if (match) begin
                    hit_next        = 1'b1;
                    hit_handle_next = head_handle;
                end
                steps_next = steps_reg - CNT_W'(1);
                if (steps_reg == CNT_W'(1)) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = (hit_reg || match) ? STAT_OK : STAT_NOT_FOUND;
                    rid_next       = '0;
                    rhandle_next   = '0;
                    if (!scan_del_reg) begin
                        if (hit_reg) begin
                            rhandle_next = hit_handle_reg;
                        end else if (match) begin
                            rhandle_next = head_handle;
                        end
                    end
                    rcount_next = ECOUNT_W'(count_next);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        steps_reg      <= steps_next;
        key_reg        <= key_next;
        scan_del_reg   <= scan_del_next;
        hit_handle_reg <= hit_handle_next;
        status_reg     <= status_next;
        rhandle_reg    <= rhandle_next;
        rid_reg        <= rid_next;
        rcount_reg     <= rcount_next;
    end

    assign count    = count_reg;
    assign m_valid  = out_valid_reg;
    assign m_status = status_reg;
    assign m_handle = rhandle_reg;
    assign m_id     = rid_reg;
    assign m_count  = rcount_reg;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("fill count above capacity");

    // While a scan runs, no result is pending and no command is taken.
    a_scan_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (!out_valid_reg && !s_ready))
        else $error("result or command during a scan");

    // A pop from a non-empty store removes exactly one entry.
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_cmd == CMD_POP && count_reg != '0)
            |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not remove one entry");

    // A scan ends with a result in the output register.
    a_scan_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && steps_reg == CNT_W'(1)) |=> out_valid_reg)
        else $error("scan ended without a result");

    // At most one chain move is issued in a cycle.
    a_one_move: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({chain.append, chain.drop, chain.rotate}))
        else $error("conflicting chain moves");

endmodule : kfl_ctrl

`default_nettype wire
